FILE: hw/rtl/spg_pkg.sv
package spg_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_RUN      = 2'd1,
    OP_STOP     = 2'd2,
    OP_STEP_RUN = 2'd3
  } op_t;

  // commanded / applied motor status
  typedef enum logic [1:0] {
    ST_DISABLED = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_FREE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SM_OFF  = 2'd0,
    SM_RUN  = 2'd1,
    SM_DONE = 2'd2
  } step_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_APPLY = 2'd1,
    BK_DIV   = 2'd2,
    BK_EMIT  = 2'd3
  } back_state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_RATE       = 2'd0;
  localparam logic [1:0] CFG_PULSES_PER_STEP = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF_TICKS   = 2'd2;

  localparam logic [15:0] BASE_RATE_RST       = 16'd10000;
  localparam logic [15:0] PULSES_PER_STEP_RST = 16'd400;
  localparam logic [15:0] HOLDOFF_TICKS_RST   = 16'd50;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    op_t         op;
    logic [15:0] speed;
    logic        direction;
    logic [15:0] steps;
  } item_t;

  typedef struct packed {
    logic [15:0] base_rate;
    logic [15:0] pulses_per_step;
    logic [15:0] holdoff_ticks;
  } cfg_t;

endpackage

FILE: hw/rtl/spg_front.sv
module spg_front import spg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // speed[15:0], direction[16], steps[32:17]
  input  logic [1:0]            in_tuser,  // operation[1:0]
  output logic                  q_valid,
  output item_t                 q_item,
  input  logic                  q_pop
);

  localparam int DEPTH = 2;
  localparam logic [1:0] DEPTH_CNT = 2'(DEPTH);

  item_t       q_r [DEPTH];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  item_t       new_item;

  assign in_tready = (count_r != DEPTH_CNT);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = q_r[rd_ptr_r];

  // decode the transaction into an item, only step-run keeps the step target
  always_comb begin
    new_item.op        = op_t'(in_tuser);
    new_item.speed     = in_tdata[15:0];
    new_item.direction = in_tdata[16];
    new_item.steps     = (op_t'(in_tuser) == OP_STEP_RUN) ? in_tdata[32:17] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) count_r <= count_r + 2'd1;
      else if (!push && q_pop) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT) else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != 2'd0)) else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue count did not grow on push");

endmodule

FILE: hw/rtl/spg_div.sv
module spg_div import spg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [15:0]          rem_r;
  logic [15:0]          quo_r;
  logic [15:0]          div_r;
  logic [16:0]          shifted;
  logic [16:0]          diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r, quo_r[15]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = (shifted >= {1'b0, div_r});

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == DIV_CNT_W'(1));
      if (start) cnt_r <= DIV_CNT_W'(DIV_STEPS);
      else if (busy) cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 16'd0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      rem_r <= ge ? diff[15:0] : shifted[15:0];
      quo_r <= {quo_r[14:0], ge};
    end
  end

endmodule

FILE: hw/rtl/spg_back.sv
module spg_back import spg_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  localparam int CW   = COUNT_WIDTH;
  localparam int CMPW = (CW > 16) ? CW : 16;

  back_state_t state_r, state_nxt;

  status_t     cmd_status_r;
  logic [15:0] cmd_speed_r;
  logic        cmd_dir_r;
  step_mode_t  step_mode_r;
  logic [15:0] step_target_r;
  status_t     app_status_r;
  logic [15:0] app_speed_r;
  logic        app_dir_r;
  step_mode_t  app_mode_r;
  logic [15:0] app_target_r;
  logic [15:0] period_r;
  logic [CW-1:0] tick_cnt_r;
  logic [CW-1:0] pulse_cnt_r;
  logic [CW-1:0] steps_done_r;
  logic [CW-1:0] holdoff_r;
  logic          pulse_r;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [15:0]   per;
  logic [15:0]   pps;
  logic [CW-1:0] tick_inc;
  logic [CW-1:0] pulse_inc;
  logic [CW-1:0] steps_inc;
  logic          fire;
  logic          step_adv;
  logic          holdoff_max;
  logic          changed;
  logic          do_apply;
  logic          step_finish;
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [15:0]   div_quo;
  logic          out_load;

  spg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.base_rate),
    .divisor  (cmd_speed_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // tick arithmetic, zero period and zero pulses per step act as one
  assign per         = (period_r == 16'd0) ? 16'd1 : period_r;
  assign pps         = (cfg.pulses_per_step == 16'd0) ? 16'd1 : cfg.pulses_per_step;
  assign tick_inc    = tick_cnt_r + CW'(1);
  assign pulse_inc   = pulse_cnt_r + CW'(1);
  assign steps_inc   = steps_done_r + CW'(1);
  assign fire        = CMPW'(tick_inc) >= CMPW'(per);
  assign step_adv    = CMPW'(pulse_inc) >= CMPW'(pps);
  assign holdoff_max = &holdoff_r;

  assign changed = (cmd_status_r != app_status_r) || (cmd_speed_r != app_speed_r) ||
                   (cmd_dir_r != app_dir_r) || (step_mode_r != app_mode_r) ||
                   (step_target_r != app_target_r);
  assign do_apply    = (CMPW'(holdoff_r) > CMPW'(cfg.holdoff_ticks)) && changed;
  assign step_finish = (step_mode_r == SM_RUN) &&
                       (CMPW'(steps_done_r) >= CMPW'(step_target_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_APPLY;
      BK_APPLY: state_nxt = (do_apply && cmd_speed_r != 16'd0) ? BK_DIV : BK_EMIT;
      BK_DIV:   if (div_done) state_nxt = BK_EMIT;
      BK_EMIT:  if (!out_valid_r || out_tready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_pop = q_valid;
      BK_APPLY: div_start = do_apply && (cmd_speed_r != 16'd0);
      BK_DIV:   ;
      BK_EMIT:  out_load = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      cmd_status_r  <= ST_DISABLED;
      cmd_speed_r   <= 16'd0;
      cmd_dir_r     <= 1'b0;
      step_mode_r   <= SM_OFF;
      step_target_r <= 16'd0;
      app_status_r  <= ST_DISABLED;
      app_speed_r   <= 16'd0;
      app_dir_r     <= 1'b0;
      app_mode_r    <= SM_OFF;
      app_target_r  <= 16'd0;
      period_r      <= BASE_RATE_RST;
      tick_cnt_r    <= '0;
      pulse_cnt_r   <= '0;
      steps_done_r  <= '0;
      holdoff_r     <= '0;
      pulse_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (q_pop) begin
        case (q_item.op)
          OP_TICK: begin
            if (!holdoff_max) holdoff_r <= holdoff_r + CW'(1);
            if (fire) begin
              tick_cnt_r <= '0;
              if (cmd_status_r == ST_RUNNING) begin
                pulse_r <= ~pulse_r;
                if (step_adv) begin
                  pulse_cnt_r  <= '0;
                  steps_done_r <= steps_inc;
                end else begin
                  pulse_cnt_r <= pulse_inc;
                end
              end
            end else begin
              tick_cnt_r <= tick_inc;
            end
          end
          OP_RUN: begin
            cmd_speed_r <= q_item.speed;
            if (q_item.speed != 16'd0) begin
              cmd_status_r <= ST_RUNNING;
              cmd_dir_r    <= q_item.direction;
            end else begin
              cmd_status_r <= ST_FREE;
            end
          end
          OP_STOP: cmd_status_r <= ST_DISABLED;
          default: begin
            step_mode_r   <= SM_RUN;
            step_target_r <= q_item.steps;
            cmd_status_r  <= ST_RUNNING;
            cmd_speed_r   <= q_item.speed;
            cmd_dir_r     <= q_item.direction;
            steps_done_r  <= '0;
          end
        endcase
      end

      // latch changed commanded settings once the holdoff has run out; end a finished step run
      if (state_r == BK_APPLY) begin
        if (do_apply) begin
          holdoff_r    <= '0;
          app_status_r <= cmd_status_r;
          app_speed_r  <= cmd_speed_r;
          app_dir_r    <= cmd_dir_r;
          app_mode_r   <= step_mode_r;
          app_target_r <= step_target_r;
        end
        if (step_finish) step_mode_r <= SM_DONE;
        if (step_finish || (do_apply && cmd_speed_r == 16'd0)) cmd_status_r <= ST_DISABLED;
      end

      if (div_done) period_r <= div_quo;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b00, 16'(steps_done_r), (step_mode_r == SM_DONE),
                     (cmd_status_r == ST_RUNNING), app_status_r, app_dir_r, pulse_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (div_busy || div_done)) else $error("waiting on idle divider");

  a_apply_clears_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_APPLY && do_apply) |=> (holdoff_r == '0))
    else $error("holdoff not cleared on apply");

  a_pop_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == BK_APPLY)) else $error("popped item not applied");

endmodule

FILE: hw/rtl/stepper_pulse_generator_top.sv
// an input transaction is queued, then passes the back end's idle, apply and emit states into
// the output register, with a divide state after apply (serial divider, one quotient bit per
// cycle) when a command with nonzero speed applies; the back end takes one item at a time
// a 2-entry input queue takes new transactions while the back end works or the output waits
// reset: rst_n synchronous active low; motor disabled, counters zero, registers at defaults
module stepper_pulse_generator_top import spg_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // speed[15:0], direction[16], steps[32:17]
  input  logic [1:0]            in_tuser,   // operation[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pulse_level[0], direction_out[1], enable_state[3:2], running[4],
  // step_done[5], step_count[21:6]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers, base_rate only takes effect on the next applied nonzero-speed command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_rate       <= BASE_RATE_RST;
      cfg_r.pulses_per_step <= PULSES_PER_STEP_RST;
      cfg_r.holdoff_ticks   <= HOLDOFF_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BASE_RATE:       cfg_r.base_rate       <= cfg_wdata;
        CFG_PULSES_PER_STEP: cfg_r.pulses_per_step <= cfg_wdata;
        CFG_HOLDOFF_TICKS:   cfg_r.holdoff_ticks   <= cfg_wdata;
        default:             ;  // unmapped index, write dropped
      endcase
    end
  end

  // front end: decodes each transaction and queues it
  spg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back end: tick counting, command apply, period divide and result register
  spg_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
